/* rtl/ptrs_pkg.sv */
// ----------------------------------------------------------------------------
// Periodic task release scheduler package
// Shared constants, command codes, state encoding and unit handshake types.
// ----------------------------------------------------------------------------
package ptrs_pkg;

  // Slot table geometry.
  localparam int NumSlots = 8;
  localparam int SlotW    = 3;
  localparam int PeriodW  = 16;
  localparam int MaskW    = 8;
  localparam int CmdW     = 3;

  // Command codes carried in a request.
  typedef enum logic [CmdW-1:0] {
    CMD_TICK    = 3'd0,
    CMD_CREATE  = 3'd1,
    CMD_SUSPEND = 3'd2,
    CMD_RESUME  = 3'd3,
    CMD_DELETE  = 3'd4
  } cmd_e;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_EMIT
  } state_e;

  // Start request to the shared remainder unit.
  typedef struct packed {
    logic               start;
    logic [PeriodW-1:0] dividend;
    logic [PeriodW-1:0] divisor;
  } mod_req_t;

  // Completion status from the shared remainder unit.
  typedef struct packed {
    logic done;
    logic rem_zero;
  } mod_rsp_t;

endpackage

/* rtl/ptrs_if.sv */
// ----------------------------------------------------------------------------
// Scheduler channel interfaces
// Valid/ready channels for incoming command requests and outgoing results.
// ----------------------------------------------------------------------------
interface ptrs_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [2:0]  task_slot;
  logic [15:0] period;
  logic        has_task;

  modport source (output valid, command, task_slot, period, has_task, input ready);
  modport sink   (input valid, command, task_slot, period, has_task, output ready);
endinterface

interface ptrs_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  due_mask;
  logic [15:0] tick_value;

  modport source (output valid, due_mask, tick_value, input ready);
  modport sink   (input valid, due_mask, tick_value, output ready);
endinterface

/* rtl/ptrs_mod_unit.sv */
// ----------------------------------------------------------------------------
// Shared remainder unit
// Restoring division, one quotient bit per cycle; reports whether the
// remainder is zero after PeriodW steps.
// ----------------------------------------------------------------------------
module ptrs_mod_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ptrs_pkg::mod_req_t req_i,
  output ptrs_pkg::mod_rsp_t rsp_o
);
  import ptrs_pkg::*;

  localparam int CntW = $clog2(PeriodW);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [PeriodW:0]   rem_q, rem_d;
  logic [PeriodW-1:0] dvd_q, dvd_d;
  logic [PeriodW-1:0] div_q, div_d;
  logic [PeriodW:0]   rem_sh;

  // Start loads the operands; otherwise one restoring step: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    rem_sh = {rem_q[PeriodW-1:0], dvd_q[PeriodW-1]};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(PeriodW - 1);
      rem_d  = '0;
      dvd_d  = req_i.dividend;
      div_d  = req_i.divisor;
    end else if (busy_q) begin
      dvd_d = {dvd_q[PeriodW-2:0], 1'b0};
      if (rem_sh >= {1'b0, div_q}) begin
        rem_d = rem_sh - {1'b0, div_q};
      end else begin
        rem_d = rem_sh;
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    div_q <= div_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.rem_zero = (rem_q == '0);

endmodule

/* rtl/periodic_task_release_scheduler_core.sv */
// ----------------------------------------------------------------------------
// Periodic task release scheduler core
// Keeps the slot table and, on each tick, walks the slots through one shared
// remainder unit to build the mask of released slots.
// ----------------------------------------------------------------------------
// Timing: a non-tick request goes from S_IDLE to S_EMIT, where its result
// is loaded into the result register; a tick walks the slots in S_SCAN and,
// for each eligible slot, waits in S_WAIT for the shared 16-step remainder unit.
// Throughput: one request at a time; ready is high only when idle, and the
// result register lets the next request in while a result still waits.
// Reset clears the tick counter and all slot flags and periods.
module periodic_task_release_scheduler_core (
  input logic clk_i,
  input logic rst_ni,
  ptrs_in_if.sink    req_i,
  ptrs_out_if.source rsp_o
);
  import ptrs_pkg::*;

  state_e             state_q, state_d;
  logic [SlotW-1:0]   slot_q, slot_d;
  logic [MaskW-1:0]   mask_q, mask_d;
  logic [PeriodW-1:0] tick_q, tick_d;
  logic [PeriodW-1:0] period_q [NumSlots];
  logic [NumSlots-1:0] resumed_q, resumed_d;
  logic [NumSlots-1:0] present_q, present_d;
  logic               out_valid_q, out_valid_d;
  logic [MaskW-1:0]   out_mask_q, out_mask_d;
  logic [PeriodW-1:0] out_tick_q, out_tick_d;
  logic               accept;
  logic               per_we;
  logic               eligible;
  logic               last_slot;
  mod_req_t           mod_req;
  mod_rsp_t           mod_rsp;

  assign accept    = req_i.valid && req_i.ready;
  assign eligible  = present_q[slot_q] && resumed_q[slot_q] && (period_q[slot_q] != '0);
  assign last_slot = (slot_q == SlotW'(NumSlots - 1));

  // Shared remainder unit.
  ptrs_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  // Sequencer: apply commands, walk the slots on a tick, emit the result.
  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    mask_d      = mask_q;
    tick_d      = tick_q;
    resumed_d   = resumed_q;
    present_d   = present_q;
    per_we      = 1'b0;
    out_valid_d = out_valid_q;
    out_mask_d  = out_mask_q;
    out_tick_d  = out_tick_q;
    req_i.ready = (state_q == S_IDLE);
    mod_req.start    = 1'b0;
    mod_req.dividend = tick_q;
    mod_req.divisor  = period_q[slot_q];

    if (rsp_o.valid && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          mask_d  = '0;
          slot_d  = '0;
          state_d = S_EMIT;
          case (req_i.command)
            CMD_TICK: begin
              tick_d  = tick_q + PeriodW'(1);
              state_d = S_SCAN;
            end
            CMD_CREATE: begin
              per_we                     = 1'b1;
              resumed_d[req_i.task_slot] = 1'b1;
              present_d[req_i.task_slot] = req_i.has_task;
            end
            CMD_SUSPEND: resumed_d[req_i.task_slot] = 1'b0;
            CMD_RESUME:  resumed_d[req_i.task_slot] = 1'b1;
            CMD_DELETE:  present_d[req_i.task_slot] = 1'b0;
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (eligible) begin
          mod_req.start = 1'b1;
          state_d       = S_WAIT;
        end else if (last_slot) begin
          state_d = S_EMIT;
        end else begin
          slot_d = slot_q + SlotW'(1);
        end
      end
      S_WAIT: begin
        if (mod_rsp.done) begin
          mask_d[slot_q] = mod_rsp.rem_zero;
          if (last_slot) begin
            state_d = S_EMIT;
          end else begin
            slot_d  = slot_q + SlotW'(1);
            state_d = S_SCAN;
          end
        end
      end
      S_EMIT: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_mask_d  = mask_q;
          out_tick_d  = tick_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state and slot flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      slot_q      <= '0;
      mask_q      <= '0;
      tick_q      <= '0;
      resumed_q   <= '0;
      present_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      mask_q      <= mask_d;
      tick_q      <= tick_d;
      resumed_q   <= resumed_d;
      present_q   <= present_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Slot periods; reset to zero so an unused slot never fires.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumSlots; i++) begin
        period_q[i] <= '0;
      end
    end else if (per_we) begin
      period_q[req_i.task_slot] <= req_i.period;
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    out_mask_q <= out_mask_d;
    out_tick_q <= out_tick_d;
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.due_mask   = out_mask_q;
  assign rsp_o.tick_value = out_tick_q;

  // The remainder unit is started only while scanning a slot.
  a_start_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_req.start |-> (state_q == S_SCAN))
    else $error("remainder unit started outside slot scan");

  // A finished remainder is only seen while the sequencer waits for it.
  a_done_in_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_rsp.done |-> (state_q == S_WAIT))
    else $error("remainder result arrived while not waiting");

  // Only a tick request moves the counter.
  a_tick_only : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.command != CMD_TICK)) |=> $stable(tick_q))
    else $error("tick counter changed on a non-tick request");

endmodule

/* dv/periodic_task_release_scheduler_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Periodic task release scheduler checker
// Watches the request and result channels and keeps its own slot table and
// tick counter. Every accepted result is compared field by field with the
// oldest predicted one. The failure count goes back to the testbench top.
// ----------------------------------------------------------------------------
module periodic_task_release_scheduler_checker (
  input  logic clk_i,
  input  logic rst_ni,
  ptrs_in_if   req_mon,
  ptrs_out_if  rsp_mon,
  output int   fail_count_o,
  output int   pending_o,
  output int   checked_o,
  output int   released_o
);
  import ptrs_pkg::*;

  typedef struct packed {
    logic [MaskW-1:0]   due_mask;
    logic [PeriodW-1:0] tick_value;
  } release_result_t;

  // Shadow copy of the scheduler state.
  logic [PeriodW-1:0]  tick_now;
  logic [PeriodW-1:0]  period_tbl [NumSlots];
  logic [NumSlots-1:0] resumed_tbl;
  logic [NumSlots-1:0] present_tbl;

  release_result_t expected_releases[$];
  int              mismatches;
  int              results_checked;
  int              slot_releases;

  assign fail_count_o = mismatches;
  assign pending_o    = expected_releases.size();
  assign checked_o    = results_checked;
  assign released_o   = slot_releases;

  // A slot is due when it is present, resumed and its nonzero period divides
  // the new counter value.
  function automatic logic [MaskW-1:0] slots_due(input logic [PeriodW-1:0] now);
    logic [MaskW-1:0] due;
    due = '0;
    for (int i = 0; i < NumSlots && i < MaskW; i++) begin
      if (present_tbl[i] && resumed_tbl[i] && period_tbl[i] != '0 &&
          (now % period_tbl[i]) == '0) begin
        due[i] = 1'b1;
      end
    end
    return due;
  endfunction

  // Applies one request to the shadow state and returns its result.
  task automatic predict_request(input logic [CmdW-1:0] cmd,
                                 input logic [SlotW-1:0] slot,
                                 input logic [PeriodW-1:0] period,
                                 input logic has_task,
                                 output release_result_t res);
    res.due_mask = '0;
    if (cmd == CMD_TICK) begin
      tick_now     = tick_now + 1'b1;
      res.due_mask = slots_due(tick_now);
    end else if (int'(slot) < NumSlots) begin
      case (cmd)
        CMD_CREATE: begin
          period_tbl[slot]  = period;
          resumed_tbl[slot] = 1'b1;
          present_tbl[slot] = has_task;
        end
        CMD_SUSPEND: resumed_tbl[slot] = 1'b0;
        CMD_RESUME:  resumed_tbl[slot] = 1'b1;
        CMD_DELETE:  present_tbl[slot] = 1'b0;
        default: ;
      endcase
    end
    res.tick_value = tick_now;
  endtask

  task automatic note_mismatch(input string what, input int want, input int got);
    if (mismatches < 10) begin
      $display("mismatch at %0t: %s expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    end
    mismatches++;
  endtask

  // Predict on each accepted request, then check each accepted result.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    release_result_t want;
    release_result_t got;
    if (!rst_ni) begin
      tick_now    = '0;
      resumed_tbl = '0;
      present_tbl = '0;
      for (int i = 0; i < NumSlots; i++) period_tbl[i] = '0;
      expected_releases.delete();
      mismatches      = 0;
      results_checked = 0;
      slot_releases   = 0;
    end else begin
      if (req_mon.valid && req_mon.ready) begin
        predict_request(req_mon.command, req_mon.task_slot, req_mon.period,
                        req_mon.has_task, want);
        expected_releases.push_back(want);
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        got.due_mask   = rsp_mon.due_mask;
        got.tick_value = rsp_mon.tick_value;
        if (expected_releases.size() == 0) begin
          note_mismatch("unexpected result, due_mask", 0, got.due_mask);
        end else begin
          want = expected_releases.pop_front();
          if (got.due_mask !== want.due_mask) begin
            note_mismatch("due_mask", want.due_mask, got.due_mask);
          end
          if (got.tick_value !== want.tick_value) begin
            note_mismatch("tick_value", want.tick_value, got.tick_value);
          end
          results_checked++;
          slot_releases += $countones(want.due_mask);
        end
      end
    end
  end

endmodule

/* dv/periodic_task_release_scheduler_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Periodic task release scheduler testbench
// Drives command requests into the core and applies random back pressure on
// the result side. A directed part covers each command, zero periods, slots
// without a task and unknown commands; random traffic follows.
// ----------------------------------------------------------------------------
module periodic_task_release_scheduler_core_tb;
  import ptrs_pkg::*;

  localparam int             CycleLimit   = 4_000_000;
  localparam int             RandomItems  = 650;
  localparam int             HoldCycles   = 300;
  localparam int             DrainCycles  = 200;
  localparam logic [CmdW-1:0] CmdUnknownLo = 3'd5;
  localparam logic [CmdW-1:0] CmdUnknownHi = 3'd7;

  logic clk_i;
  logic rst_ni;

  ptrs_in_if  req_if ();
  ptrs_out_if rsp_if ();

  int               fail_count;
  int               pending;
  int               checked;
  int               released;
  int               requests_sent;
  int               cycles;
  logic [PeriodW-1:0] ticks_sent;
  bit               idle_enable;
  bit               rx_hold_pending;

  periodic_task_release_scheduler_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  periodic_task_release_scheduler_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_mon      (req_if),
    .rsp_mon      (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .released_o   (released)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_hold_pending) begin
        rx_hold_pending = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        rsp_if.ready <= !(idle_enable && $urandom_range(99) < 23);
      end
    end
  end

  // Offers one request and returns at the edge where it is accepted. Valid
  // stays high so that back-to-back requests need no second assignment.
  task automatic offer_request(input logic [CmdW-1:0] cmd,
                               input logic [SlotW-1:0] slot,
                               input logic [PeriodW-1:0] period,
                               input logic has_task);
    while (idle_enable && $urandom_range(99) < 23) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.command   <= cmd;
    req_if.task_slot <= slot;
    req_if.period    <= period;
    req_if.has_task  <= has_task;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    if (cmd == CMD_TICK) ticks_sent++;
    requests_sent++;
  endtask

  task automatic tick_once();
    offer_request(CMD_TICK, SlotW'($urandom), PeriodW'($urandom), 1'($urandom));
  endtask

  // Mostly well-formed traffic with small periods so that slots fire often.
  task automatic offer_random_request();
    int               pick;
    int               span;
    logic [PeriodW-1:0] period;
    pick = $urandom_range(99);
    span = $urandom_range(9);
    if (span == 0)      period = '0;
    else if (span <= 6) period = PeriodW'($urandom_range(12, 1));
    else if (span == 7) period = PeriodW'($urandom_range(255, 13));
    else                period = PeriodW'($urandom);
    if (pick < 45) begin
      tick_once();
    end else if (pick < 65) begin
      offer_request(CMD_CREATE, SlotW'($urandom), period, $urandom_range(9) != 0);
    end else if (pick < 73) begin
      offer_request(CMD_SUSPEND, SlotW'($urandom), PeriodW'($urandom), 1'($urandom));
    end else if (pick < 81) begin
      offer_request(CMD_RESUME, SlotW'($urandom), PeriodW'($urandom), 1'($urandom));
    end else if (pick < 89) begin
      offer_request(CMD_DELETE, SlotW'($urandom), PeriodW'($urandom), 1'($urandom));
    end else if (pick < 96) begin
      offer_request(CMD_CREATE, SlotW'($urandom), PeriodW'($urandom), 1'($urandom));
    end else begin
      offer_request(CmdW'($urandom_range(CmdUnknownHi, CmdUnknownLo)), SlotW'($urandom),
                    PeriodW'($urandom), 1'($urandom));
    end
  endtask

  // Reset, stimulus and verdict.
  initial begin
    rst_ni           <= 1'b0;
    req_if.valid     <= 1'b0;
    req_if.command   <= CMD_TICK;
    req_if.task_slot <= '0;
    req_if.period    <= '0;
    req_if.has_task  <= 1'b0;
    idle_enable     = 1'b1;
    rx_hold_pending = 1'b0;
    ticks_sent      = '0;
    requests_sent   = 0;
    cycles          = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every command, zero period, slot without a task, extremes.
    offer_request(CMD_CREATE, 3'd0, 16'd1, 1'b1);
    offer_request(CMD_CREATE, 3'd1, 16'd0, 1'b1);
    offer_request(CMD_CREATE, 3'd2, 16'd2, 1'b0);
    offer_request(CMD_CREATE, 3'd3, 16'd3, 1'b1);
    offer_request(CMD_CREATE, 3'd7, 16'hFFFF, 1'b1);
    offer_request(CMD_CREATE, 3'd6, 16'h8000, 1'b1);
    repeat (3) tick_once();
    offer_request(CMD_SUSPEND, 3'd3, 16'hFFFF, 1'b1);
    repeat (2) tick_once();
    offer_request(CMD_RESUME, 3'd3, 16'h0000, 1'b0);
    tick_once();
    // Suspend and resume of a slot that holds no task.
    offer_request(CMD_SUSPEND, 3'd5, 16'h0000, 1'b0);
    offer_request(CMD_RESUME, 3'd5, 16'h0000, 1'b0);
    tick_once();
    offer_request(CMD_DELETE, 3'd0, 16'h0000, 1'b0);
    tick_once();
    offer_request(CmdUnknownLo, 3'd0, 16'h0000, 1'b0);
    offer_request(CmdUnknownLo + 3'd1, 3'd7, 16'hFFFF, 1'b1);
    offer_request(CmdUnknownHi, 3'd4, 16'h5555, 1'b1);
    offer_request(CMD_CREATE, 3'd4, 16'd4, 1'b1);
    tick_once();

    // Random traffic, with one stretch free of idling and one long hold-off
    // at the result side so that the core backs up into its input.
    for (int n = 0; n < RandomItems; n++) begin
      idle_enable = !(n >= 150 && n < 300);
      if (n == 400) rx_hold_pending = 1'b1;
      offer_random_request();
    end
    req_if.valid <= 1'b0;
    idle_enable = 1'b1;

    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("summary: %0d requests, %0d of them ticks, under random stalls on both sides",
             requests_sent, ticks_sent);
    $display("summary: %0d results checked, %0d slot releases predicted", checked, released);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/ptrs_pkg.sv
rtl/ptrs_if.sv
rtl/ptrs_mod_unit.sv
rtl/periodic_task_release_scheduler_core.sv
dv/periodic_task_release_scheduler_checker.sv
dv/periodic_task_release_scheduler_core_tb.sv
